### design/itrf_pkg.sv
package itrf_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int LIST_SLOTS  = 4;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int LIST_USED   = (LIST_SLOTS < 4) ? LIST_SLOTS : 4;
  localparam int CFG_W       = 32;
  localparam int CNT_W       = 3;

  typedef logic [IDX_W-1:0] itrf_idx_t;

  // power-on contents of the store
  localparam logic [7:0] STORE_INIT [STORE_DEPTH] = '{default: 8'h00};

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_READ = 2'd1,
    REQ_END  = 2'd2
  } itrf_req_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_PTR_SET   = 3'd1,
    ST_CMD       = 3'd2,
    ST_WR_DENIED = 3'd3,
    ST_RD_DENIED = 3'd4
  } itrf_status_t;

  typedef enum logic [2:0] {
    REG_RO_ADDRS  = 3'd0,
    REG_RO_COUNT  = 3'd1,
    REG_WO_ADDRS  = 3'd2,
    REG_WO_COUNT  = 3'd3,
    REG_CMD_CODES = 3'd4,
    REG_CMD_COUNT = 3'd5
  } itrf_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] ro_addrs;
    logic [CNT_W-1:0] ro_count;
    logic [CFG_W-1:0] wo_addrs;
    logic [CNT_W-1:0] wo_count;
    logic [CFG_W-1:0] cmd_codes;
    logic [CNT_W-1:0] cmd_count;
  } itrf_cfg_t;

  function automatic logic list_has(logic [CFG_W-1:0] packed_list,
                                    logic [CNT_W-1:0] count,
                                    logic [7:0] value);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < LIST_USED; i++) begin
      if ((CNT_W'(i) < count) && (packed_list[8*i +: 8] == value)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

### design/itrf_if.sv
interface itrf_req_if (input logic clk);
  logic                valid;
  logic                ready;
  itrf_pkg::itrf_req_t req_type;
  logic [7:0]          rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface itrf_rsp_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [2:0] status;
  logic [7:0] pointer_now;

  modport source (output valid, output read_data, output status, output pointer_now,
                  input ready);
  modport sink (input valid, input read_data, input status, input pointer_now,
                output ready);
endinterface

### design/i2c_target_register_file_unit.sv
// path: an accepted request beat passes through the input register and then the output register to the response
// throughput: one beat per cycle while the response side is ready; the store is read ahead at the next pointer
// stalls on the response side hold the output register and back-pressure the input register
// reset: pointer, pointer-set flag and all configuration registers clear to zero,
// store entries read their power-on table value until first written, no clearing pass
module i2c_target_register_file_unit (
  input  logic                       clk,
  input  logic                       rst,
  itrf_req_if.sink                   req,
  itrf_rsp_if.source                 rsp,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [itrf_pkg::CFG_W-1:0] cfg_data
);

  itrf_pkg::itrf_cfg_t    cfg;

  logic                   inq_v;
  itrf_pkg::itrf_req_t    inq_req;
  logic [7:0]             inq_byte;
  logic                   adv;

  logic [7:0]             pointer;
  logic [7:0]             pointer_next;
  logic                   pointer_set;
  logic                   pointer_set_next;

  itrf_pkg::itrf_status_t status_next;
  logic [7:0]             data_next;
  logic                   st_we;
  logic [7:0]             st_rdata;

  logic                   ro_hit;
  logic                   wo_hit;
  logic                   cmd_hit;

  itrf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  itrf_store u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (st_we),
    .waddr (pointer[itrf_pkg::IDX_W-1:0]),
    .wdata (inq_byte),
    .raddr (pointer_next[itrf_pkg::IDX_W-1:0]),
    .rdata (st_rdata)
  );

  assign adv       = inq_v && (!rsp.valid || rsp.ready);
  assign req.ready = !inq_v || adv;

  assign ro_hit  = itrf_pkg::list_has(cfg.ro_addrs, cfg.ro_count, pointer);
  assign wo_hit  = itrf_pkg::list_has(cfg.wo_addrs, cfg.wo_count, pointer);
  assign cmd_hit = itrf_pkg::list_has(cfg.cmd_codes, cfg.cmd_count, inq_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_v <= 1'b0;
    end else if (req.valid && req.ready) begin
      inq_v <= 1'b1;
    end else if (adv) begin
      inq_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      inq_req  <= req.req_type;
      inq_byte <= req.rx_byte;
    end
  end

  always_comb begin
    pointer_next     = pointer;
    pointer_set_next = pointer_set;
    status_next      = itrf_pkg::ST_DONE;
    data_next        = '0;
    st_we            = 1'b0;
    if (adv) begin
      case (inq_req)
        itrf_pkg::REQ_BYTE: begin
          if (pointer_set) begin
            if (ro_hit) begin
              status_next = itrf_pkg::ST_WR_DENIED;
            end else begin
              st_we        = 1'b1;
              pointer_next = pointer + 8'd1;
            end
          end else if (cmd_hit) begin
            status_next = itrf_pkg::ST_CMD;
          end else begin
            pointer_next     = inq_byte;
            pointer_set_next = 1'b1;
            status_next      = itrf_pkg::ST_PTR_SET;
          end
        end
        itrf_pkg::REQ_READ: begin
          if (wo_hit) begin
            status_next = itrf_pkg::ST_RD_DENIED;
          end else begin
            data_next    = st_rdata;
            pointer_next = pointer + 8'd1;
          end
        end
        itrf_pkg::REQ_END: begin
          pointer_set_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer     <= '0;
      pointer_set <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      pointer     <= pointer_next;
      pointer_set <= pointer_set_next;
      if (adv) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.read_data   <= data_next;
      rsp.status      <= status_next;
      rsp.pointer_now <= pointer_next;
    end
  end

  a_data_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != itrf_pkg::ST_DONE) |-> rsp.read_data == 8'd0)
    else $error("read data nonzero outside a granted read");

  a_write_advances: assert property (@(posedge clk) disable iff (rst)
    (adv && inq_req == itrf_pkg::REQ_BYTE && pointer_set && !ro_hit)
    |=> pointer == $past(pointer) + 8'd1)
    else $error("granted write did not advance the pointer");

  a_denied_holds: assert property (@(posedge clk) disable iff (rst)
    (adv && (status_next == itrf_pkg::ST_WR_DENIED || status_next == itrf_pkg::ST_RD_DENIED))
    |=> $stable(pointer))
    else $error("denied access moved the pointer");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && inq_req == itrf_pkg::REQ_END) |=> !pointer_set)
    else $error("end of transfer left the pointer marked set");

  a_pointer_echo: assert property (@(posedge clk) disable iff (rst)
    adv |=> rsp.pointer_now == pointer)
    else $error("reported pointer differs from the pointer register");

endmodule

### design/itrf_cfg.sv
module itrf_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [itrf_pkg::CFG_W-1:0]  cfg_data,
  output itrf_pkg::itrf_cfg_t         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (itrf_pkg::itrf_reg_t'(cfg_index))
        itrf_pkg::REG_RO_ADDRS:  cfg.ro_addrs  <= cfg_data;
        itrf_pkg::REG_RO_COUNT:  cfg.ro_count  <= cfg_data[itrf_pkg::CNT_W-1:0];
        itrf_pkg::REG_WO_ADDRS:  cfg.wo_addrs  <= cfg_data;
        itrf_pkg::REG_WO_COUNT:  cfg.wo_count  <= cfg_data[itrf_pkg::CNT_W-1:0];
        itrf_pkg::REG_CMD_CODES: cfg.cmd_codes <= cfg_data;
        itrf_pkg::REG_CMD_COUNT: cfg.cmd_count <= cfg_data[itrf_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/itrf_store.sv
module itrf_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  itrf_pkg::itrf_idx_t waddr,
  input  logic [7:0]         wdata,
  input  itrf_pkg::itrf_idx_t raddr,
  output logic [7:0]         rdata
);

  logic [7:0]                        mem [itrf_pkg::STORE_DEPTH];
  logic [7:0]                        mem_q;
  logic [itrf_pkg::STORE_DEPTH-1:0]  written;
  itrf_pkg::itrf_idx_t               raddr_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // entries not yet written read back their power-on value
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      raddr_q <= '0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      raddr_q <= raddr;
    end
  end

  assign rdata = written[raddr_q] ? mem_q : itrf_pkg::STORE_INIT[raddr_q];

endmodule

### test/i2c_target_register_file_unit_test.sv
`timescale 1ns / 100ps

module i2c_target_register_file_unit_test;
  import itrf_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 6;
  localparam int SEND_IDLE [4] = '{0, 73, 0, 8};
  localparam int RECV_STALL [4] = '{0, 0, 73, 8};

  typedef struct {
    logic [7:0]   read_data;
    itrf_status_t status;
    logic [7:0]   pointer_now;
  } access_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  itrf_req_if req (clk);
  itrf_rsp_if rsp (clk);

  i2c_target_register_file_unit dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [7:0]     reg_image [STORE_DEPTH];
  logic [7:0]     ptr_image;
  logic           ptr_loaded;
  itrf_cfg_t      cfg_image;
  access_result_t pending_results [$];
  int             send_idle_pct;
  int             stall_pct;
  int             calm_beats;
  int             failures;
  int             cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver side
  always @(negedge clk) begin
    if (!rst) begin
      rsp.ready <= (calm_beats > 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    access_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected beat: read_data %0d status %0d pointer_now %0d",
               rsp.read_data, rsp.status, rsp.pointer_now);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.read_data !== want.read_data) begin
          $error("read_data expected %0d actual %0d", want.read_data, rsp.read_data);
          failures++;
        end
        if (rsp.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp.status);
          failures++;
        end
        if (rsp.pointer_now !== want.pointer_now) begin
          $error("pointer_now expected %0d actual %0d", want.pointer_now, rsp.pointer_now);
          failures++;
        end
      end
    end
  end

  function automatic bit slot_match(input logic [31:0] slots, input logic [2:0] used,
                                    input logic [7:0] value);
    int limit;
    limit = (used > LIST_SLOTS) ? LIST_SLOTS : used;
    if (limit > 4) limit = 4;
    for (int i = 0; i < limit; i++) begin
      if (slots[8*i +: 8] == value) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic access_result_t predict_register_access(input logic [1:0] kind,
                                                             input logic [7:0] data);
    access_result_t r;
    r.read_data = 8'h00;
    r.status    = ST_DONE;
    case (kind)
      REQ_BYTE: begin
        if (ptr_loaded) begin
          if (slot_match(cfg_image.ro_addrs, cfg_image.ro_count, ptr_image)) begin
            r.status = ST_WR_DENIED;
          end else begin
            reg_image[IDX_W'(ptr_image % STORE_DEPTH)] = data;
            ptr_image = ptr_image + 8'd1;
          end
        end else if (slot_match(cfg_image.cmd_codes, cfg_image.cmd_count, data)) begin
          r.status = ST_CMD;
        end else begin
          ptr_image  = data;
          ptr_loaded = 1'b1;
          r.status   = ST_PTR_SET;
        end
      end
      REQ_READ: begin
        if (slot_match(cfg_image.wo_addrs, cfg_image.wo_count, ptr_image)) begin
          r.status = ST_RD_DENIED;
        end else begin
          r.read_data = reg_image[IDX_W'(ptr_image % STORE_DEPTH)];
          ptr_image = ptr_image + 8'd1;
        end
      end
      REQ_END: ptr_loaded = 1'b0;
      default: ;
    endcase
    r.pointer_now = ptr_image;
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
    while (calm_beats == 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.req_type <= itrf_req_t'(kind);
    req.rx_byte  <= data;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_results.push_back(predict_register_access(kind, data));
    if (calm_beats > 0) begin
      calm_beats--;
    end else if ($urandom_range(49) == 0) begin
      calm_beats = 24;
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    case (index)
      REG_RO_ADDRS:  cfg_image.ro_addrs  = value;
      REG_RO_COUNT:  cfg_image.ro_count  = value[2:0];
      REG_WO_ADDRS:  cfg_image.wo_addrs  = value;
      REG_WO_COUNT:  cfg_image.wo_count  = value[2:0];
      REG_CMD_CODES: cfg_image.cmd_codes = value;
      REG_CMD_COUNT: cfg_image.cmd_count = value[2:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_lists(input logic [31:0] ro, input logic [2:0] ro_n,
                             input logic [31:0] wo, input logic [2:0] wo_n,
                             input logic [31:0] cmd, input logic [2:0] cmd_n);
    write_reg(REG_RO_ADDRS, ro);
    write_reg(REG_RO_COUNT, 32'(ro_n));
    write_reg(REG_WO_ADDRS, wo);
    write_reg(REG_WO_COUNT, 32'(wo_n));
    write_reg(REG_CMD_CODES, cmd);
    write_reg(REG_CMD_COUNT, 32'(cmd_n));
    cfg_we <= 1'b0;
  endtask

  task automatic load_lists(input logic [31:0] ro, input logic [2:0] ro_n,
                            input logic [31:0] wo, input logic [2:0] wo_n,
                            input logic [31:0] cmd, input logic [2:0] cmd_n);
    drain_results();
    write_lists(ro, ro_n, wo, wo_n, cmd, cmd_n);
  endtask

  // clustered slots make denials and command hits common
  function automatic logic [31:0] random_slots();
    logic [31:0] slots;
    logic [7:0]  base;
    slots = $urandom;
    base  = 8'($urandom);
    if ($urandom_range(1) == 0) begin
      for (int i = 0; i < 4; i++) slots[8*i +: 8] = base + 8'($urandom_range(7));
    end
    return slots;
  endfunction

  function automatic logic [7:0] pick_pointer();
    logic [31:0] slots;
    int          k;
    k = $urandom_range(3);
    case ($urandom_range(4))
      0: slots = cfg_image.ro_addrs;
      1: slots = cfg_image.wo_addrs;
      default: return 8'($urandom);
    endcase
    return slots[8*k +: 8] - 8'($urandom_range(2));
  endfunction

  function automatic logic [7:0] pick_command();
    int used;
    int k;
    used = (cfg_image.cmd_count > 4) ? 4 : cfg_image.cmd_count;
    k = $urandom_range(used - 1);
    return cfg_image.cmd_codes[8*k +: 8];
  endfunction

  task automatic run_traffic(input int target);
    int         sent;
    int         len;
    int         shape;
    logic [1:0] kind;
    logic [7:0] start;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(3) == 0) begin
        kind = 2'($urandom_range(3));
        send_beat(kind, 8'($urandom));
        if (kind != REQ_UNUSED) sent++;
      end else begin
        len   = $urandom_range(1, 8);
        start = pick_pointer();
        shape = $urandom_range(9);
        if (cfg_image.cmd_count != 0 && $urandom_range(3) == 0) begin
          send_beat(REQ_BYTE, pick_command());
          sent++;
        end
        send_beat(REQ_BYTE, start);
        sent++;
        if (shape < 3) begin
          // write a run, then read it back
          for (int i = 0; i < len; i++) send_beat(REQ_BYTE, 8'($urandom));
          send_beat(REQ_END, 8'($urandom));
          send_beat(REQ_BYTE, start);
          for (int i = 0; i < len; i++) send_beat(REQ_READ, 8'($urandom));
          sent += 2 * len + 2;
        end else begin
          for (int i = 0; i < len; i++) begin
            if (shape < 6) kind = REQ_BYTE;
            else if (shape < 9) kind = REQ_READ;
            else kind = 2'($urandom_range(1));
            send_beat(kind, 8'($urandom));
          end
          sent += len;
        end
        if ($urandom_range(9) != 0) begin
          send_beat(REQ_END, 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  task automatic test_reset_state();
    send_beat(REQ_READ, 8'h00);
    send_beat(REQ_UNUSED, 8'hFF);
    send_beat(REQ_BYTE, 8'hFF);
    send_beat(REQ_BYTE, 8'hA5);
    send_beat(REQ_BYTE, 8'h00);
    send_beat(REQ_END, 8'h00);
    send_beat(REQ_BYTE, 8'hFF);
    send_beat(REQ_READ, 8'hFF);
    send_beat(REQ_READ, 8'h00);
    send_beat(REQ_END, 8'hFF);
    send_beat(REQ_END, 8'h00);
  endtask

  task automatic test_full_lists();
    load_lists(32'h4030_20FF, 3'd4, 32'h0041_3121, 3'd4, 32'hFF80_0100, 3'd7);
    send_beat(REQ_BYTE, 8'h80);
    send_beat(REQ_BYTE, 8'hFF);
    send_beat(REQ_BYTE, 8'h00);
    send_beat(REQ_BYTE, 8'h20);
    send_beat(REQ_BYTE, 8'h11);
    send_beat(REQ_READ, 8'h00);
    send_beat(REQ_READ, 8'h00);
    send_beat(REQ_BYTE, 8'h33);
    send_beat(REQ_END, 8'h00);
  endtask

  task automatic test_partial_lists();
    drain_results();
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    write_lists(32'h4030_20FF, 3'd1, 32'h0041_3121, 3'd0, 32'hFF80_0100, 3'd2);
    send_beat(REQ_BYTE, 8'h80);
    send_beat(REQ_BYTE, 8'h5A);
    send_beat(REQ_END, 8'h00);
    send_beat(REQ_BYTE, 8'h01);
    send_beat(REQ_BYTE, 8'hFF);
    send_beat(REQ_BYTE, 8'h77);
    send_beat(REQ_END, 8'h00);
    send_beat(REQ_READ, 8'h00);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE[p];
      stall_pct     = RECV_STALL[p];
      load_lists(random_slots(), 3'($urandom), random_slots(), 3'($urandom),
                 random_slots(), 3'($urandom));
      run_traffic(210);
      case (p)
        0: load_lists(32'h0, 3'd0, 32'h0, 3'd0, 32'h0, 3'd0);
        1: load_lists(32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 3'd7);
        2: load_lists(32'h0, 3'd7, 32'h0, 3'd4, 32'h0, 3'd4);
        default: load_lists(32'h0302_0100, 3'd4, 32'h0706_0504, 3'd4, 32'hFEFD_FCFB, 3'd4);
      endcase
      run_traffic(210);
    end
  endtask

  task automatic test_pause_for_results();
    send_idle_pct = 0;
    stall_pct     = 40;
    load_lists(random_slots(), 3'd3, random_slots(), 3'd3, random_slots(), 3'd1);
    run_traffic(60);
    drain_results();
    run_traffic(60);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_RO_ADDRS;
    cfg_data      = '0;
    req.valid     = 1'b0;
    req.req_type  = REQ_BYTE;
    req.rx_byte   = 8'h00;
    rsp.ready     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    calm_beats    = 0;
    failures      = 0;
    cycles        = 0;
    ptr_image     = 8'h00;
    ptr_loaded    = 1'b0;
    cfg_image     = '0;
    for (int a = 0; a < STORE_DEPTH; a++) reg_image[a] = STORE_INIT[a];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_full_lists();
    test_partial_lists();
    test_random_traffic();
    test_pause_for_results();
    drain_results();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
design/itrf_pkg.sv
design/itrf_if.sv
design/itrf_cfg.sv
design/itrf_store.sv
design/i2c_target_register_file_unit.sv
test/i2c_target_register_file_unit_test.sv
